// ===== rtl/conv3d_same_pad_leaky_relu_unit_assert.svh =====
// assertion macros used by the convolution unit controller
`ifndef CONV3D_SAME_PAD_LEAKY_RELU_UNIT_ASSERT_SVH
`define CONV3D_SAME_PAD_LEAKY_RELU_UNIT_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define C3D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on the next edge
`define C3D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/c3d_pkg.sv =====
// types and constants shared by the convolution unit
`timescale 1ns / 1ps
`default_nettype none
package c3d_pkg;

  typedef enum logic [1:0] {
    CMD_WR_TAP  = 2'd0,
    CMD_WR_BIAS = 2'd1,
    CMD_WR_VOX  = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_IN_HEIGHT = 3'd0,
    REG_IN_WIDTH  = 3'd1,
    REG_IN_DEPTH  = 3'd2,
    REG_IN_CH     = 3'd3,
    REG_FILT_H    = 3'd4,
    REG_FILT_W    = 3'd5,
    REG_FILT_D    = 3'd6,
    REG_OUT_CH    = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIAS,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_OUT
  } state_e;

  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned AccW    = 48;

  // controller -> datapath
  typedef struct packed {
    logic clr_acc;    // load accumulator with bias term
    logic mac_en;     // accumulate product of read data
    logic tap_valid;  // current tap addresses a voxel inside the volume
    logic round_en;   // form activated result
    logic zero_res;   // out-of-range request gives zero
  } dp_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/c3d_if.sv =====
// valid/ready channels of the convolution unit
`timescale 1ns / 1ps
`default_nettype none
interface c3d_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  chan;
  logic [2:0]  depth_pos;
  logic [4:0]  row_pos;
  logic [4:0]  col_pos;
  logic signed [15:0] value;
  modport source (output valid, command, chan, depth_pos, row_pos, col_pos, value,
                  input ready);
  modport sink (input valid, command, chan, depth_pos, row_pos, col_pos, value,
                output ready);
endinterface

interface c3d_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result_value;
  logic               saturated;
  modport source (output valid, result_value, saturated, input ready);
  modport sink (input valid, result_value, saturated, output ready);
endinterface

interface c3d_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [7:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/conv3d_same_pad_leaky_relu_unit.sv =====
// 3-d same-padded convolution with bias, leaky relu and q8.8 saturation
//  channel | dir | payload
//  in_if   | in  | command, chan, depth_pos, row_pos, col_pos, value
//  cfg_if  | in  | index, data (size registers 0..7)
//  out_if  | out | result_value, saturated
// a write command is stored on acceptance; a compute performs one multiply-accumulate per cycle
// through the voxel and tap ram ports, for every tap of every input channel.
// an out-of-range compute skips the mac and drain states and returns zero.
// stores are not cleared after reset; the size registers reset to their defaults.
// no new item is taken while a result waits for out_if.ready.
`timescale 1ns / 1ps
`default_nettype none
module conv3d_same_pad_leaky_relu_unit
  import c3d_pkg::*;
#(
  parameter int unsigned MaxRows = 32,
  parameter int unsigned MaxCols = 32,
  parameter int unsigned MaxDepth = 8,
  parameter int unsigned MaxInCh = 4,
  parameter int unsigned MaxOutCh = 8,
  parameter int unsigned MaxTap = 5
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  c3d_in_if.sink    in_if,
  c3d_cfg_if.sink   cfg_if,
  c3d_out_if.source out_if
);
  localparam int unsigned VoxDepth = MaxInCh * MaxDepth * MaxRows * MaxCols;
  localparam int unsigned TapDepth = MaxOutCh * MaxTap * MaxTap * MaxTap;

  logic vox_we, tap_we, bias_we;
  logic [$clog2(VoxDepth)-1:0] vox_addr;
  logic [$clog2(TapDepth)-1:0] tap_addr;
  logic [$clog2(MaxOutCh)-1:0] bias_addr;
  dp_cmd_t cmd;

  c3d_ctrl #(
    .MaxRows(MaxRows), .MaxCols(MaxCols), .MaxDepth(MaxDepth),
    .MaxInCh(MaxInCh), .MaxOutCh(MaxOutCh), .MaxTap(MaxTap)
  ) u_ctrl (
    .clk_i, .rst_ni, .in_if, .cfg_if,
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .vox_we_o(vox_we), .vox_addr_o(vox_addr),
    .tap_we_o(tap_we), .tap_addr_o(tap_addr),
    .bias_we_o(bias_we), .bias_addr_o(bias_addr),
    .cmd_o(cmd)
  );

  c3d_datapath #(
    .VoxDepth(VoxDepth), .TapDepth(TapDepth), .BiasDepth(MaxOutCh)
  ) u_dp (
    .clk_i, .rst_ni,
    .vox_we_i(vox_we), .vox_addr_i(vox_addr),
    .tap_we_i(tap_we), .tap_addr_i(tap_addr),
    .bias_we_i(bias_we), .bias_addr_i(bias_addr),
    .wdata_i(in_if.value), .cmd_i(cmd),
    .res_o(out_if.result_value), .sat_o(out_if.saturated)
  );
endmodule
`default_nettype wire

// ===== rtl/c3d_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module c3d_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/c3d_datapath.sv =====
// stores, multiply-accumulate, rounding, leaky relu and saturation
`timescale 1ns / 1ps
`default_nettype none
module c3d_datapath
  import c3d_pkg::*;
#(
  parameter int unsigned VoxDepth = 4096,
  parameter int unsigned TapDepth = 1000,
  parameter int unsigned BiasDepth = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        vox_we_i,
  input  wire logic [$clog2(VoxDepth)-1:0] vox_addr_i,
  input  wire logic                        tap_we_i,
  input  wire logic [$clog2(TapDepth)-1:0] tap_addr_i,
  input  wire logic                        bias_we_i,
  input  wire logic [$clog2(BiasDepth)-1:0] bias_addr_i,
  input  wire logic signed [15:0]          wdata_i,
  input  wire dp_cmd_t                     cmd_i,
  output logic signed [15:0]               res_o,
  output logic                             sat_o
);
  logic [15:0] vox_rd, tap_rd, bias_rd;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [31:0] prod_q;
  logic prod_vld_q;
  logic signed [AccW+7:0] scaled;
  logic signed [AccW+7:0] rnd;
  logic signed [AccW+7:0] shifted;
  logic signed [15:0] res_q;
  logic sat_q;

  c3d_ram #(.Width(16), .Depth(VoxDepth)) u_vox (
    .clk_i, .we_i(vox_we_i), .waddr_i(vox_addr_i), .wdata_i(wdata_i),
    .raddr_i(vox_addr_i), .rdata_o(vox_rd));
  c3d_ram #(.Width(16), .Depth(TapDepth)) u_tap (
    .clk_i, .we_i(tap_we_i), .waddr_i(tap_addr_i), .wdata_i(wdata_i),
    .raddr_i(tap_addr_i), .rdata_o(tap_rd));
  c3d_ram #(.Width(16), .Depth(BiasDepth)) u_bias (
    .clk_i, .we_i(bias_we_i), .waddr_i(bias_addr_i), .wdata_i(wdata_i),
    .raddr_i(bias_addr_i), .rdata_o(bias_rd));

  // tap_valid is delayed to line up with the registered read and the product register
  logic tv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q       <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      tv_q       <= cmd_i.mac_en & cmd_i.tap_valid;
      prod_vld_q <= tv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(vox_rd) * $signed(tap_rd);
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.clr_acc) begin
      acc_d = AccW'($signed(bias_rd)) <<< 8;
    end else if (prod_vld_q) begin
      acc_d = acc_q + AccW'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // negative sums scaled by 41 (=32+8+1), shifts and adds only
  always_comb begin
    if (acc_q[AccW-1]) begin
      scaled = ((AccW+8)'(acc_q) <<< 5) + ((AccW+8)'(acc_q) <<< 3) + (AccW+8)'(acc_q);
      rnd    = scaled + (AccW+8)'(1 <<< 19);
      shifted = rnd >>> 20;
    end else begin
      scaled = (AccW+8)'(acc_q);
      rnd    = scaled + (AccW+8)'(128);
      shifted = rnd >>> 8;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.round_en) begin
      if (cmd_i.zero_res) begin
        res_q <= '0;
        sat_q <= 1'b0;
      end else if (shifted > (AccW+8)'(32767)) begin
        res_q <= 16'sh7fff;
        sat_q <= 1'b1;
      end else if (shifted < -(AccW+8)'(32768)) begin
        res_q <= -16'sh8000;
        sat_q <= 1'b1;
      end else begin
        res_q <= shifted[15:0];
        sat_q <= 1'b0;
      end
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;
endmodule
`default_nettype wire

// ===== rtl/c3d_ctrl.sv =====
// sequencer: command decode, loop counters, handshakes
`timescale 1ns / 1ps
`default_nettype none
module c3d_ctrl
  import c3d_pkg::*;
#(
  parameter int unsigned MaxRows = 32,
  parameter int unsigned MaxCols = 32,
  parameter int unsigned MaxDepth = 8,
  parameter int unsigned MaxInCh = 4,
  parameter int unsigned MaxOutCh = 8,
  parameter int unsigned MaxTap = 5,
  localparam int unsigned VoxDepth = MaxInCh * MaxDepth * MaxRows * MaxCols,
  localparam int unsigned TapDepth = MaxOutCh * MaxTap * MaxTap * MaxTap,
  localparam int unsigned VoxAw = $clog2(VoxDepth),
  localparam int unsigned TapAw = $clog2(TapDepth),
  localparam int unsigned BiasAw = $clog2(MaxOutCh)
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  c3d_in_if.sink          in_if,
  c3d_cfg_if.sink         cfg_if,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            vox_we_o,
  output logic [VoxAw-1:0] vox_addr_o,
  output logic            tap_we_o,
  output logic [TapAw-1:0] tap_addr_o,
  output logic            bias_we_o,
  output logic [BiasAw-1:0] bias_addr_o,
  output dp_cmd_t         cmd_o
);
  `include "conv3d_same_pad_leaky_relu_unit_assert.svh"

  state_e state_q, state_d;
  logic [5:0] ih_q, iw_q;
  logic [3:0] id_q, oc_q;
  logic [2:0] ic_q, fh_q, fw_q, fd_q;
  // clamped sizes
  logic [9:0] ih, iw, id, ic, fh, fw, fd, oc, pad;

  // request latched at acceptance
  logic [2:0] ch_q;
  logic [9:0] d_q, r_q, c_q;
  logic [9:0] z_q, kd_q, kr_q, kc_q, z_d, kd_d, kr_d, kc_d;
  logic       oor_q, oor_d;
  logic [2:0] drain_q, drain_d;
  logic signed [11:0] vd, vr, vc;
  logic last_tap;
  logic acc_in, acc_cfg;

  function automatic logic [9:0] clamp(input logic [9:0] v, input int unsigned hi);
    if (v == 10'd0) return 10'd1;
    if (v > 10'(hi)) return 10'(hi);
    return v;
  endfunction

  assign ih = clamp(10'(ih_q), MaxRows);
  assign iw = clamp(10'(iw_q), MaxCols);
  assign id = clamp(10'(id_q), MaxDepth);
  assign ic = clamp(10'(ic_q), MaxInCh);
  assign fh = clamp(10'(fh_q), MaxTap);
  assign fw = clamp(10'(fw_q), MaxTap);
  assign fd = clamp(10'(fd_q), MaxTap);
  assign oc = clamp(10'(oc_q), MaxOutCh);
  assign pad = (fh - 10'd1) >> 1;

  assign acc_in  = in_if.valid & in_if.ready;
  assign acc_cfg = cfg_if.valid & cfg_if.ready;
  assign cfg_if.ready = 1'b1;
  assign in_if.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ih_q <= 6'd32; iw_q <= 6'd32; id_q <= 4'd8; ic_q <= 3'd1;
      fh_q <= 3'd3;  fw_q <= 3'd3;  fd_q <= 3'd3; oc_q <= 4'd1;
    end else if (acc_cfg && cfg_if.index < CfgIdxW'(8)) begin
      unique case (reg_idx_e'(cfg_if.index[2:0]))
        REG_IN_HEIGHT: ih_q <= cfg_if.data[5:0];
        REG_IN_WIDTH:  iw_q <= cfg_if.data[5:0];
        REG_IN_DEPTH:  id_q <= cfg_if.data[3:0];
        REG_IN_CH:     ic_q <= cfg_if.data[2:0];
        REG_FILT_H:    fh_q <= cfg_if.data[2:0];
        REG_FILT_W:    fw_q <= cfg_if.data[2:0];
        REG_FILT_D:    fd_q <= cfg_if.data[2:0];
        REG_OUT_CH:    oc_q <= cfg_if.data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      ch_q <= in_if.chan;
      d_q  <= 10'(in_if.depth_pos);
      r_q  <= 10'(in_if.row_pos);
      c_q  <= 10'(in_if.col_pos);
    end
  end

  assign vd = $signed({2'b0, d_q}) + $signed({2'b0, kd_q}) - $signed({2'b0, pad});
  assign vr = $signed({2'b0, r_q}) + $signed({2'b0, kr_q}) - $signed({2'b0, pad});
  assign vc = $signed({2'b0, c_q}) + $signed({2'b0, kc_q}) - $signed({2'b0, pad});
  assign last_tap = (kc_q == fw - 10'd1) && (kr_q == fh - 10'd1) &&
                    (kd_q == fd - 10'd1) && (z_q == ic - 10'd1);

  // write address decode in idle, tap/voxel walk during mac
  always_comb begin
    vox_we_o = 1'b0; tap_we_o = 1'b0; bias_we_o = 1'b0;
    bias_addr_o = BiasAw'(in_if.chan);
    vox_addr_o = VoxAw'(((32'(in_if.chan) * MaxDepth + 32'(in_if.depth_pos)) * MaxRows
                 + 32'(in_if.row_pos)) * MaxCols + 32'(in_if.col_pos));
    tap_addr_o = TapAw'(((32'(in_if.chan) * MaxTap + 32'(in_if.depth_pos)) * MaxTap
                 + 32'(in_if.row_pos)) * MaxTap + 32'(in_if.col_pos));
    if (state_q == ST_IDLE) begin
      if (acc_in) begin
        unique case (cmd_e'(in_if.command))
          CMD_WR_TAP: tap_we_o = (32'(in_if.chan) < MaxOutCh) &&
            (32'(in_if.depth_pos) < MaxTap) && (32'(in_if.row_pos) < MaxTap) &&
            (32'(in_if.col_pos) < MaxTap);
          CMD_WR_BIAS: bias_we_o = 32'(in_if.chan) < MaxOutCh;
          CMD_WR_VOX: vox_we_o = (32'(in_if.chan) < MaxInCh) &&
            (32'(in_if.depth_pos) < MaxDepth) && (32'(in_if.row_pos) < MaxRows) &&
            (32'(in_if.col_pos) < MaxCols);
          CMD_COMPUTE: ;
          default: ;
        endcase
      end
    end else begin
      bias_addr_o = BiasAw'(ch_q);
      vox_addr_o = VoxAw'(((32'(z_q) * MaxDepth + 32'(vd[9:0])) * MaxRows
                   + 32'(vr[9:0])) * MaxCols + 32'(vc[9:0]));
      tap_addr_o = TapAw'(((32'(ch_q) * MaxTap + 32'(kd_q)) * MaxTap
                   + 32'(kr_q)) * MaxTap + 32'(kc_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      z_q <= '0; kd_q <= '0; kr_q <= '0; kc_q <= '0;
      oor_q <= 1'b0; drain_q <= '0;
    end else begin
      state_q <= state_d;
      z_q <= z_d; kd_q <= kd_d; kr_q <= kr_d; kc_q <= kc_d;
      oor_q <= oor_d; drain_q <= drain_d;
    end
  end

  always_comb begin
    state_d = state_q;
    z_d = z_q; kd_d = kd_q; kr_d = kr_q; kc_d = kc_q;
    oor_d = oor_q; drain_d = drain_q;
    cmd_o = '0;
    cmd_o.zero_res = oor_q;
    cmd_o.tap_valid = !vd[11] && !vr[11] && !vc[11] && (vd[9:0] < id) &&
                      (vr[9:0] < ih) && (vc[9:0] < iw);
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_in && cmd_e'(in_if.command) == CMD_COMPUTE) begin
          oor_d = (10'(in_if.chan) >= oc) || (10'(in_if.depth_pos) >= id) ||
                  (10'(in_if.row_pos) >= ih) || (10'(in_if.col_pos) >= iw);
          z_d = '0; kd_d = '0; kr_d = '0; kc_d = '0;
          state_d = ST_BIAS;
        end
      end
      // bias read data arrives this cycle
      ST_BIAS: begin
        cmd_o.clr_acc = 1'b1;
        state_d = oor_q ? ST_ROUND : ST_MAC;
      end
      ST_MAC: begin
        cmd_o.mac_en = 1'b1;
        if (last_tap) begin
          drain_d = 3'd0;
          state_d = ST_DRAIN;
        end else if (kc_q != fw - 10'd1) begin
          kc_d = kc_q + 10'd1;
        end else begin
          kc_d = '0;
          if (kr_q != fh - 10'd1) begin
            kr_d = kr_q + 10'd1;
          end else begin
            kr_d = '0;
            if (kd_q != fd - 10'd1) begin
              kd_d = kd_q + 10'd1;
            end else begin
              kd_d = '0;
              z_d = z_q + 10'd1;
            end
          end
        end
      end
      // read, product and accumulate stages empty out
      ST_DRAIN: begin
        drain_d = drain_q + 3'd1;
        if (drain_q == 3'd2) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `C3D_ASSERT(a_ready_idle, in_if.ready == (state_q == ST_IDLE), "ready outside idle")
  `C3D_ASSERT(a_one_write, $onehot0({vox_we_o, tap_we_o, bias_we_o}), "two stores written")
  `C3D_ASSERT_NEXT(a_round_out, state_q == ST_ROUND, out_valid_o, "result not presented")
endmodule
`default_nettype wire
